### rtl/core/sstg_pkg.sv
// ----------------------------------------------------------------------------
// sstg_pkg
// Shared types, constants and elaboration-time helpers for the stereo sine
// tone generator.
// ----------------------------------------------------------------------------
package sstg_pkg;

  localparam int SINE_TABLE_ENTRIES_DEF  = 1024;
  localparam int SINE_AMPLITUDE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W    = 32;
  localparam int VOL_W      = 17;
  localparam int PAN_W      = 18;
  localparam int LEVEL_W    = 14;
  localparam int SAMPLE_W   = 15;
  localparam int SCALE_W    = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_VOLUME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN         = 3'd4;

  localparam logic [VOL_W-1:0]   UNITY       = 17'h10000;
  localparam logic [SCALE_W-1:0] FULL_SCALE  = 14'd16000;
  localparam logic [63:0]        Q60_HALF_PI = 64'h1921FB54442D1847;

  localparam longint unsigned TAYLOR_DIV [1:15] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE,
    ST_PAN
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // (a * b) >> 60, elaboration use only
  function automatic longint unsigned mul_q60(input longint unsigned a,
                                              input longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // sin(x) on [0, pi/2], Q60 in and out
  function automatic longint unsigned sin_q60(input longint unsigned x);
    longint unsigned x2, term, pos, neg;
    x2   = mul_q60(x, x);
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 15; n++) begin
      term = mul_q60(term, x2) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic logic signed [PAN_W-1:0] sat_pan(input logic signed [PAN_W-1:0] p);
    logic signed [PAN_W-1:0] r;
    r = p;
    if (p > 18'sd65536) begin
      r = 18'sd65536;
    end else if (p < -18'sd65536) begin
      r = -18'sd65536;
    end
    return r;
  endfunction

endpackage

### rtl/core/sstg_ctrl.sv
// ----------------------------------------------------------------------------
// sstg_ctrl
// Sequencer: takes one request beat, steps the datapath through lookup,
// scaling and panning, then loads the output register when it is free.
// ----------------------------------------------------------------------------
module sstg_ctrl
  import sstg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_stall = 1'b1;
    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          st_nxt      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        st_nxt     = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        st_nxt    = ST_PAN;
      end
      ST_PAN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/sstg_dp.sv
// ----------------------------------------------------------------------------
// sstg_dp
// Datapath: control registers, phase accumulator, quarter-wave sine ROM,
// volume and pan multipliers, and the output register.
// ----------------------------------------------------------------------------
module sstg_dp
  import sstg_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES  = SINE_TABLE_ENTRIES_DEF,
  parameter int SINE_AMPLITUDE_BITS = SINE_AMPLITUDE_BITS_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_last_in_buffer,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_sample,
  output logic signed [SAMPLE_W-1:0] out_right_sample,
  output logic                       out_buffer_end
);

  localparam int Q      = SINE_TABLE_ENTRIES;
  localparam int B      = SINE_AMPLITUDE_BITS;
  localparam int RW     = B + 1;
  localparam int IDX_W  = $clog2(Q + 1);
  localparam int PROD_W = 30 + IDX_W;
  localparam int VP_W   = 2 * VOL_W;
  localparam int VF_W   = VP_W + SCALE_W;
  localparam int MF_W   = RW + LEVEL_W;
  localparam int PF_W   = LEVEL_W + VOL_W;

  localparam longint unsigned STEP  = Q60_HALF_PI / Q;
  localparam longint unsigned REM   = Q60_HALF_PI % Q;
  localparam longint unsigned ROUND = 64'd1 << (59 - B);
  localparam longint unsigned PEAK  = 64'd1 << B;
  localparam int              SHIFT = 60 - B;

  typedef logic [RW-1:0] rom_t [0:Q];

  function automatic rom_t build_rom();
    rom_t            t;
    longint unsigned x, racc, s, v;
    x    = 64'd0;
    racc = 64'd0;
    for (int k = 0; k <= Q; k++) begin
      s = sin_q60(x);
      v = (s + ROUND) >> SHIFT;
      if (v > PEAK) begin
        v = PEAK;
      end
      t[k] = v[RW-1:0];
      x    = x + STEP;
      racc = racc + REM;
      if (racc >= longint'(Q)) begin
        racc = racc - longint'(Q);
        x    = x + 64'd1;
      end
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                       enable_r;
  logic [PHASE_W-1:0]         inc_r;
  logic [VOL_W-1:0]           tvol_r;
  logic [VOL_W-1:0]           mvol_r;
  logic signed [PAN_W-1:0]    pan_r;
  logic [PHASE_W-1:0]         phase_r;

  logic                       last_r;
  logic                       active_r;
  logic                       neg_r;
  logic [IDX_W-1:0]           addr_r;
  logic [VP_W-1:0]            vprod_r;
  logic [RW-1:0]              rom_q_r;
  logic [LEVEL_W-1:0]         vol_r;
  logic [LEVEL_W-1:0]         mag_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;
  logic                       out_end_r;

  logic [PROD_W-1:0]          idx_prod;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           addr;
  logic [VF_W-1:0]            vol_full;
  logic [MF_W-1:0]            mag_full;
  logic [VOL_W-1:0]           gain_l;
  logic [VOL_W-1:0]           gain_r;
  logic [PF_W-1:0]            left_full;
  logic [PF_W-1:0]            right_full;
  logic signed [SAMPLE_W-1:0] left_mag;
  logic signed [SAMPLE_W-1:0] right_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      inc_r    <= '0;
      tvol_r   <= '0;
      mvol_r   <= UNITY;
      pan_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable_r <= cfg_wdata[0];
        CFG_PHASE_INC:   inc_r    <= cfg_wdata[PHASE_W-1:0];
        CFG_TONE_VOLUME: tvol_r   <= sat_vol(cfg_wdata[VOL_W-1:0]);
        CFG_MASTER_VOL:  mvol_r   <= sat_vol(cfg_wdata[VOL_W-1:0]);
        CFG_PAN:         pan_r    <= sat_pan(cfg_wdata[PAN_W-1:0]);
        default: ;
      endcase
    end
  end

  // quarter-wave index and mirror
  always_comb begin
    idx_prod = PROD_W'(phase_r[29:0]) * PROD_W'(Q);
    idx      = idx_prod[PROD_W-1:30];
    addr     = phase_r[30] ? IDX_W'(Q) - idx : idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.capture && enable_r && (inc_r != '0)) begin
      phase_r <= phase_r + inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r   <= in_last_in_buffer;
      active_r <= enable_r && (inc_r != '0);
      neg_r    <= phase_r[31];
      addr_r   <= addr;
      vprod_r  <= VP_W'(tvol_r) * VP_W'(mvol_r);
    end
  end

  assign vol_full = VF_W'(vprod_r) * VF_W'(FULL_SCALE);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rom_q_r <= SINE_ROM[addr_r];
      vol_r   <= vol_full[32 +: LEVEL_W];
    end
  end

  assign mag_full = MF_W'(rom_q_r) * MF_W'(vol_r);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      mag_r <= mag_full[B +: LEVEL_W];
    end
  end

  always_comb begin
    gain_l     = (pan_r[PAN_W-1] || (pan_r == '0)) ? UNITY : UNITY - pan_r[VOL_W-1:0];
    gain_r     = pan_r[PAN_W-1] ? UNITY + pan_r[VOL_W-1:0] : UNITY;
    left_full  = PF_W'(mag_r) * PF_W'(gain_l);
    right_full = PF_W'(mag_r) * PF_W'(gain_r);
    left_mag   = $signed({1'b0, left_full[16 +: LEVEL_W]});
    right_mag  = $signed({1'b0, right_full[16 +: LEVEL_W]});
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left_r  <= !active_r ? '0 : (neg_r ? -left_mag : left_mag);
      out_right_r <= !active_r ? '0 : (neg_r ? -right_mag : right_mag);
      out_end_r   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free     = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;
  assign out_buffer_end   = out_end_r;

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.capture |=> $stable(phase_r))
    else $error("phase moved without a request");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r >= -15'sd16000) && (out_left_r <= 15'sd16000) &&
                    (out_right_r >= -15'sd16000) && (out_right_r <= 15'sd16000))
    else $error("sample out of range");

endmodule

### rtl/core/stereo_sine_tone_generator.sv
// ----------------------------------------------------------------------------
// stereo_sine_tone_generator
// DDS sine oscillator with tone/master volume and stereo pan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one beat per sample request, carrying
//   in_last_in_buffer. Output channel (out_valid/out_stall): one stereo
//   sample per request, left/right signed, out_buffer_end copies the flag.
//   Config port: cfg_we with cfg_index 0..4 = enable, phase increment,
//   tone volume, master volume, pan. Volumes and pan saturate on write;
//   other indexes are ignored. Write only while the block is idle.
//   Sequencing: the result reaches the output register through the four-step
//   sequencer (phase index, ROM read and volume, sine scale, pan); a new
//   request is taken only once the sequencer is back in its idle step.
//   The next request is taken while a finished sample waits in the output
//   register; a stalled receiver holds the sample and blocks the sequencer
//   in its final step.
//   Reset: phase accumulator 0, disabled, increment 0, tone volume 0,
//   master volume 1.0, pan center, no output pending. Disabled or zero
//   increment gives silent samples and freezes the phase.
// ----------------------------------------------------------------------------
module stereo_sine_tone_generator
  import sstg_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES  = SINE_TABLE_ENTRIES_DEF,
  parameter int SINE_AMPLITUDE_BITS = SINE_AMPLITUDE_BITS_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_last_in_buffer,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_sample,
  output logic signed [SAMPLE_W-1:0] out_right_sample,
  output logic                       out_buffer_end
);

  cmd_t cmd;
  sts_t sts;

  sstg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sstg_dp #(
    .SINE_TABLE_ENTRIES  (SINE_TABLE_ENTRIES),
    .SINE_AMPLITUDE_BITS (SINE_AMPLITUDE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_last_in_buffer (in_last_in_buffer),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_sample   (out_left_sample),
    .out_right_sample  (out_right_sample),
    .out_buffer_end    (out_buffer_end)
  );

endmodule
